### hdl/tam_pkg.sv
package tam_pkg;

   localparam int DATA_DEPTH_DEFAULT = 256;
   localparam int LINE_COUNT_DEFAULT = 1024;
   localparam int LINK_WORDS = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int IDX_W = 16;
   localparam int WORD_W = 32;

   localparam logic [4:0] OP_ADD   = 5'd0;
   localparam logic [4:0] OP_MUL   = 5'd1;
   localparam logic [4:0] OP_SUB   = 5'd2;
   localparam logic [4:0] OP_DIV   = 5'd3;
   localparam logic [4:0] OP_COPY  = 5'd4;
   localparam logic [4:0] OP_IMM   = 5'd5;
   localparam logic [4:0] OP_JMP   = 5'd6;
   localparam logic [4:0] OP_JMPZ  = 5'd7;
   localparam logic [4:0] OP_LT    = 5'd8;
   localparam logic [4:0] OP_GT    = 5'd9;
   localparam logic [4:0] OP_EQ    = 5'd10;
   localparam logic [4:0] OP_PRINT = 5'd11;
   localparam logic [4:0] OP_AND   = 5'd12;
   localparam logic [4:0] OP_OR    = 5'd13;
   localparam logic [4:0] OP_NOT   = 5'd14;
   localparam logic [4:0] OP_CALL  = 5'd15;
   localparam logic [4:0] OP_RET   = 5'd16;

   typedef struct packed {
      logic [4:0]        cmd;
      logic [9:0]        op0;
      logic [WORD_W-1:0] op1;
      logic [IDX_W-1:0]  op0_addr;
      logic [IDX_W-1:0]  op1_addr;
      logic [IDX_W-1:0]  op2_addr;
      logic [IDX_W-1:0]  op0_line;
      logic [IDX_W-1:0]  op1_line;
      logic [IDX_W-1:0]  op2_line;
   } item_type;

   typedef struct packed {
      logic [9:0]        next_line;
      logic              print_valid;
      logic [WORD_W-1:0] print_value;
      logic              div_by_zero;
   } rsp_type;

endpackage

### hdl/tam_mod.sv
module tam_mod #(
   parameter int M = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            value,
   output logic                   ready,
   output logic [$clog2(M)-1:0]   result
);
   import tam_pkg::*;

   localparam int MW = $clog2(M);
   localparam bit IS_POW2 = (M & (M - 1)) == 0;
   localparam int SHIFT = 32 + MW;
   localparam logic [32:0] RECIP = 33'((64'd1 << SHIFT) / 64'(M));
   localparam logic [31:0] MODULUS = 32'(M);

   logic [MW-1:0] rem_ff;
   logic [MW-1:0] rem_in;
   logic [31:0]   val_ff;
   logic [31:0]   quo_ff;
   logic [31:0]   quo_in;
   logic          stage_ff;
   logic          ready_ff;
   logic [64:0]   prod;
   logic [31:0]   qm;
   logic [31:0]   diff;

   // The estimated quotient is at most one below the true one, so a single
   // conditional subtraction leaves the exact remainder.
   always_comb begin
      prod   = {33'd0, val_ff} * {32'd0, RECIP};
      quo_in = 32'(prod >> SHIFT);
      qm     = quo_ff * MODULUS;
      diff   = val_ff - qm;
      if (diff >= MODULUS) begin
         diff = diff - MODULUS;
      end
      rem_in = diff[MW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b1;
         stage_ff <= 1'b0;
      end else if (start) begin
         if (IS_POW2) begin
            rem_ff   <= value[MW-1:0];
            ready_ff <= 1'b1;
         end else begin
            val_ff   <= value;
            stage_ff <= 1'b1;
            ready_ff <= 1'b0;
         end
      end else if (!ready_ff) begin
         if (stage_ff) begin
            quo_ff   <= quo_in;
            stage_ff <= 1'b0;
         end else begin
            rem_ff   <= rem_in;
            ready_ff <= 1'b1;
         end
      end
   end

   assign ready  = ready_ff;
   assign result = rem_ff;

endmodule

### hdl/tam_fifo.sv
module tam_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   import tam_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ff;
   logic [PW-1:0]    rd_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push;
   logic             do_pop;

   assign full    = count_ff == CW'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

### hdl/tam_front.sv
module tam_front #(
   parameter int DATA_DEPTH = 256,
   parameter int LINE_COUNT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                hold,
   input  logic                push,
   output logic                full,
   input  logic [4:0]          cmd,
   input  logic [9:0]          op0,
   input  logic [31:0]         op1,
   input  logic [9:0]          op2,
   output logic                q_push,
   input  logic                q_full,
   output tam_pkg::item_type   q_item
);
   import tam_pkg::*;

   localparam int AW = $clog2(DATA_DEPTH);
   localparam int LW = $clog2(LINE_COUNT);

   logic          busy_ff;
   logic [4:0]    cmd_ff;
   logic [9:0]    op0_ff;
   logic [31:0]   op1_ff;
   logic          start;
   logic [5:0]    rdy;
   logic [AW-1:0] a0, a1, a2;
   logic [LW-1:0] l0, l1, l2;

   assign full  = busy_ff || hold;
   assign start = push && !full;

   tam_mod #(.M(DATA_DEPTH)) u_a0 (.clock, .reset, .start, .value(32'(op0)),
      .ready(rdy[0]), .result(a0));
   tam_mod #(.M(DATA_DEPTH)) u_a1 (.clock, .reset, .start, .value(op1),
      .ready(rdy[1]), .result(a1));
   tam_mod #(.M(DATA_DEPTH)) u_a2 (.clock, .reset, .start, .value(32'(op2)),
      .ready(rdy[2]), .result(a2));
   tam_mod #(.M(LINE_COUNT)) u_l0 (.clock, .reset, .start, .value(32'(op0)),
      .ready(rdy[3]), .result(l0));
   tam_mod #(.M(LINE_COUNT)) u_l1 (.clock, .reset, .start, .value(op1),
      .ready(rdy[4]), .result(l1));
   tam_mod #(.M(LINE_COUNT)) u_l2 (.clock, .reset, .start, .value(32'(op2)),
      .ready(rdy[5]), .result(l2));

   assign q_push = busy_ff && (&rdy) && !q_full;

   always_comb begin
      q_item.cmd      = cmd_ff;
      q_item.op0      = op0_ff;
      q_item.op1      = op1_ff;
      q_item.op0_addr = IDX_W'(a0);
      q_item.op1_addr = IDX_W'(a1);
      q_item.op2_addr = IDX_W'(a2);
      q_item.op0_line = IDX_W'(l0);
      q_item.op1_line = IDX_W'(l1);
      q_item.op2_line = IDX_W'(l2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cmd_ff  <= cmd;
         op0_ff  <= op0;
         op1_ff  <= op1;
      end else if (q_push) begin
         busy_ff <= 1'b0;
      end
   end

endmodule

### hdl/tam_back.sv
module tam_back #(
   parameter int DATA_DEPTH = 256,
   parameter int LINE_COUNT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   output logic                clearing,
   input  logic                q_empty,
   input  tam_pkg::item_type   q_item,
   output logic                q_pop,
   input  logic                o_full,
   output logic                o_push,
   output tam_pkg::rsp_type    o_rsp
);
   import tam_pkg::*;

   localparam int AW = $clog2(DATA_DEPTH);
   localparam int LW = $clog2(LINE_COUNT);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_RET, S_WR, S_WR2
   } state_type;

   function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] x,
                                              input logic [AW-1:0] y);
      logic [AW:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= (AW + 1)'(DATA_DEPTH)) begin
         s = s - (AW + 1)'(DATA_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] sub_wrap(input logic [AW-1:0] x,
                                              input logic [AW-1:0] y);
      logic [AW:0] s;
      s = {1'b0, x} - {1'b0, y};
      if (x < y) begin
         s = s + (AW + 1)'(DATA_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   logic [31:0]    mem [DATA_DEPTH];
   logic [31:0]    rdata_ff;
   logic [AW-1:0]  raddr;
   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   logic [31:0]    mem_wd;

   state_type      state_ff;
   item_type       it_ff;
   logic [AW-1:0]  fb_ff;
   logic [LW-1:0]  pc_ff;
   logic [AW-1:0]  clr_ff;
   logic [AW-1:0]  ra1_ff, ra2_ff, dst_ff;
   logic [31:0]    a_ff;
   logic [31:0]    res_ff;
   logic           wen_ff;
   logic [LW-1:0]  nxt_ff;
   logic           pv_ff;
   logic [31:0]    pval_ff;
   logic           dz_ff;
   logic [31:0]    quo_ff;
   logic [31:0]    rem_ff;
   logic [31:0]    dvs_ff;
   logic [5:0]     cnt_ff;

   logic [AW-1:0]  h_dst, h_src1, h_src2, h_link;
   logic [31:0]    b;
   logic [63:0]    prod;
   logic [LW-1:0]  pc_inc;
   logic [LW:0]    pc_sum;
   logic [32:0]    div_trial;
   logic           ret_start;
   logic           ret_rdy_a, ret_rdy_l;
   logic [AW-1:0]  ret_size;
   logic [LW-1:0]  ret_line;

   assign clearing = state_ff == S_CLEAR;
   assign b        = rdata_ff;
   assign prod     = a_ff * b;
   assign pc_sum   = {1'b0, pc_ff} + (LW + 1)'(1);
   assign pc_inc   = (pc_sum == (LW + 1)'(LINE_COUNT)) ? '0 : pc_sum[LW-1:0];
   assign div_trial = {rem_ff, quo_ff[31]};

   assign h_dst  = add_wrap(fb_ff, AW'(q_item.op0_addr));
   assign h_src1 = add_wrap(fb_ff, AW'(q_item.op1_addr));
   assign h_src2 = add_wrap(fb_ff, AW'(q_item.op2_addr));
   assign h_link = sub_wrap(fb_ff, AW'(LINK_WORDS));

   assign ret_start = state_ff == S_EXEC && it_ff.cmd == OP_RET;

   tam_mod #(.M(DATA_DEPTH)) u_ret_size (.clock, .reset, .start(ret_start),
      .value(a_ff), .ready(ret_rdy_a), .result(ret_size));
   tam_mod #(.M(LINE_COUNT)) u_ret_line (.clock, .reset, .start(ret_start),
      .value(b), .ready(ret_rdy_l), .result(ret_line));

   assign q_pop  = state_ff == S_IDLE && !q_empty && !o_full;
   assign o_push = (state_ff == S_WR && it_ff.cmd != OP_CALL) || state_ff == S_WR2;

   always_comb begin
      o_rsp.next_line   = 10'(nxt_ff);
      o_rsp.print_valid = pv_ff;
      o_rsp.print_value = pval_ff;
      o_rsp.div_by_zero = dz_ff;
   end

   always_comb begin
      raddr  = (state_ff == S_RD2) ? ra2_ff : ra1_ff;
      mem_we = 1'b0;
      mem_wa = dst_ff;
      mem_wd = res_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
         end
         S_WR: begin
            mem_we = wen_ff;
         end
         S_WR2: begin
            mem_we = 1'b1;
            mem_wa = add_wrap(dst_ff, AW'(1));
            mem_wd = it_ff.op1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         fb_ff    <= '0;
         pc_ff    <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DATA_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_pop) begin
                  it_ff   <= q_item;
                  dst_ff  <= h_dst;
                  wen_ff  <= 1'b0;
                  pv_ff   <= 1'b0;
                  pval_ff <= '0;
                  dz_ff   <= 1'b0;
                  nxt_ff  <= pc_inc;
                  if (q_item.cmd == OP_JMPZ || q_item.cmd == OP_PRINT) begin
                     ra1_ff <= h_dst;
                     ra2_ff <= h_src2;
                  end else if (q_item.cmd == OP_RET) begin
                     ra1_ff <= h_link;
                     ra2_ff <= add_wrap(h_link, AW'(1));
                  end else begin
                     ra1_ff <= h_src1;
                     ra2_ff <= h_src2;
                  end
                  state_ff <= S_RD1;
               end
            end
            S_RD1: begin
               state_ff <= S_RD2;
            end
            S_RD2: begin
               a_ff     <= rdata_ff;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               state_ff <= S_WR;
               case (it_ff.cmd)
                  OP_ADD: begin
                     res_ff <= a_ff + b;
                     wen_ff <= 1'b1;
                  end
                  OP_MUL: begin
                     res_ff <= prod[31:0];
                     wen_ff <= 1'b1;
                  end
                  OP_SUB: begin
                     res_ff <= a_ff - b;
                     wen_ff <= 1'b1;
                  end
                  OP_DIV: begin
                     wen_ff <= 1'b1;
                     if (b == '0) begin
                        res_ff <= '1;
                        dz_ff  <= 1'b1;
                     end else begin
                        quo_ff   <= a_ff;
                        rem_ff   <= '0;
                        dvs_ff   <= b;
                        cnt_ff   <= 6'd32;
                        state_ff <= S_DIV;
                     end
                  end
                  OP_COPY: begin
                     res_ff <= a_ff;
                     wen_ff <= 1'b1;
                  end
                  OP_IMM: begin
                     res_ff <= it_ff.op1;
                     wen_ff <= 1'b1;
                  end
                  OP_JMP: begin
                     nxt_ff <= LW'(it_ff.op0_line);
                  end
                  OP_JMPZ: begin
                     if (a_ff == '0) begin
                        nxt_ff <= LW'(it_ff.op1_line);
                     end
                  end
                  OP_LT: begin
                     res_ff <= {31'd0, a_ff < b};
                     wen_ff <= 1'b1;
                  end
                  OP_GT: begin
                     res_ff <= {31'd0, a_ff > b};
                     wen_ff <= 1'b1;
                  end
                  OP_EQ: begin
                     res_ff <= {31'd0, a_ff == b};
                     wen_ff <= 1'b1;
                  end
                  OP_PRINT: begin
                     pv_ff   <= 1'b1;
                     pval_ff <= a_ff;
                  end
                  OP_AND: begin
                     res_ff <= {31'd0, (a_ff != '0) && (b != '0)};
                     wen_ff <= 1'b1;
                  end
                  OP_OR: begin
                     res_ff <= {31'd0, (a_ff != '0) || (b != '0)};
                     wen_ff <= 1'b1;
                  end
                  OP_NOT: begin
                     res_ff <= {31'd0, a_ff == '0};
                     wen_ff <= 1'b1;
                  end
                  OP_CALL: begin
                     res_ff <= 32'(it_ff.op0) + 32'(LINK_WORDS);
                     wen_ff <= 1'b1;
                     fb_ff  <= add_wrap(dst_ff, AW'(LINK_WORDS));
                     nxt_ff <= LW'(it_ff.op2_line);
                  end
                  OP_RET: begin
                     state_ff <= S_RET;
                  end
                  default: begin
                     wen_ff <= 1'b0;
                  end
               endcase
            end
            S_DIV: begin
               if (div_trial >= {1'b0, dvs_ff}) begin
                  rem_ff <= 32'(div_trial - {1'b0, dvs_ff});
                  quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= div_trial[31:0];
                  quo_ff <= {quo_ff[30:0], 1'b0};
               end
               cnt_ff <= cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  state_ff <= S_WR;
               end
            end
            S_RET: begin
               if (ret_rdy_a && ret_rdy_l) begin
                  fb_ff    <= add_wrap(sub_wrap(ra1_ff, ret_size), AW'(LINK_WORDS));
                  nxt_ff   <= ret_line;
                  state_ff <= S_WR;
               end
            end
            S_WR: begin
               if (it_ff.cmd == OP_CALL) begin
                  state_ff <= S_WR2;
               end else begin
                  pc_ff    <= nxt_ff;
                  state_ff <= S_IDLE;
               end
            end
            S_WR2: begin
               pc_ff    <= nxt_ff;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (state_ff == S_DIV && cnt_ff == 6'd1) begin
            res_ff <= (div_trial >= {1'b0, dvs_ff}) ? {quo_ff[30:0], 1'b1}
                                                   : {quo_ff[30:0], 1'b0};
         end
      end
   end

endmodule

### hdl/three_address_memory_machine_exec.sv
// Execute unit of a memory-to-memory three-address machine.
// Instructions enter through a queue-like port: a transaction is taken when
// req_push is high and req_full is low. Results leave through a second queue:
// the oldest result sits on the rsp_ ports while rsp_empty is low and is
// removed when rsp_pop is high. Every instruction gives exactly one result.
// The front reduces the operands to data addresses and program lines: a bit
// select for a power-of-two modulus, else a registered reciprocal multiply
// and correction. It holds one instruction, so req_full is high after each
// transaction until that instruction has passed into the instruction queue.
// The back runs one instruction at a time on the data memory, which has one
// read and one write port: most operations read two words, execute and write
// back; call writes a second word, a divide yields one quotient bit per cycle,
// and return waits for its reductions of frame size and return line when
// DATA_DEPTH or LINE_COUNT is not a power of two. The front can take the next
// instruction while the back works on earlier ones in the instruction queue.
// After reset the whole data memory is cleared, one word a cycle; req_full
// stays high during this pass. If the receiver stops popping, the result
// queue fills, the back halts, and req_full stays high once the instruction
// queue has filled as well; nothing is lost.
module three_address_memory_machine_exec #(
   parameter int DATA_DEPTH = tam_pkg::DATA_DEPTH_DEFAULT,
   parameter int LINE_COUNT = tam_pkg::LINE_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [4:0]  req_cmd,
   input  logic [9:0]  req_first_operand,
   input  logic [31:0] req_second_operand,
   input  logic [9:0]  req_third_operand,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [9:0]  rsp_next_line,
   output logic        rsp_print_valid,
   output logic [31:0] rsp_print_value,
   output logic        rsp_div_by_zero
);
   import tam_pkg::*;

   logic     clearing;
   logic     fq_push, fq_full, fq_empty, fq_pop;
   item_type fq_wdata, fq_rdata;
   logic     oq_push, oq_full;
   rsp_type  oq_wdata, oq_rdata;

   tam_front #(.DATA_DEPTH(DATA_DEPTH), .LINE_COUNT(LINE_COUNT)) u_front (
      .clock, .reset,
      .hold(clearing),
      .push(req_push),
      .full(req_full),
      .cmd(req_cmd),
      .op0(req_first_operand),
      .op1(req_second_operand),
      .op2(req_third_operand),
      .q_push(fq_push),
      .q_full(fq_full),
      .q_item(fq_wdata)
   );

   tam_fifo #(.WIDTH($bits(item_type)), .DEPTH(QUEUE_DEPTH)) u_item_q (
      .clock, .reset,
      .push(fq_push), .wdata(fq_wdata), .full(fq_full),
      .pop(fq_pop), .rdata(fq_rdata), .empty(fq_empty)
   );

   tam_back #(.DATA_DEPTH(DATA_DEPTH), .LINE_COUNT(LINE_COUNT)) u_back (
      .clock, .reset,
      .clearing,
      .q_empty(fq_empty),
      .q_item(fq_rdata),
      .q_pop(fq_pop),
      .o_full(oq_full),
      .o_push(oq_push),
      .o_rsp(oq_wdata)
   );

   tam_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock, .reset,
      .push(oq_push), .wdata(oq_wdata), .full(oq_full),
      .pop(rsp_pop), .rdata(oq_rdata), .empty(rsp_empty)
   );

   assign rsp_next_line   = oq_rdata.next_line;
   assign rsp_print_valid = oq_rdata.print_valid;
   assign rsp_print_value = oq_rdata.print_value;
   assign rsp_div_by_zero = oq_rdata.div_by_zero;

endmodule
